// ===== hdl/fifo_queue_with_search_unit_macros.svh =====
// ----------------------------------------------------------------------------
// fifo queue with search unit: assertion macros
// immediate-implication and next-cycle-implication property checks
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FQS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FQS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FQS_ASSERT_IMP(label, clk, rst, ante, cons)
`define FQS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// shared types and constants of the fifo queue with search unit
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int DEPTH = 16;
  localparam int POS_W = 11;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t value;
  } req_t;

  typedef struct packed {
    status_t            status;
    word_t              data_out;
    logic [POS_W-1:0]   position;
  } rsp_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== hdl/fqs_cell.sv =====
// ----------------------------------------------------------------------------
// fqs_cell
// one queue slot: holds a word, shifts toward the head on pop, loads on push
// when it is the first free slot, and compares its word with the search key
// ----------------------------------------------------------------------------
module fqs_cell (
  input  logic               clk,
  input  logic               rst,
  input  fqs_pkg::cell_ctrl_t ctrl,
  input  fqs_pkg::word_t     word,
  input  logic               prev_valid,
  input  logic               next_valid,
  input  fqs_pkg::word_t     next_data,
  output logic               valid,
  output fqs_pkg::word_t     data,
  output logic               match
);
  import fqs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= next_valid;
    end else if (ctrl.push && !valid && prev_valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      data <= next_data;
    end else if (ctrl.push && !valid && prev_valid) begin
      data <= word;
    end
  end

  assign match = valid && (data == word);

endmodule

// ===== hdl/fqs_prio.sv =====
// ----------------------------------------------------------------------------
// fqs_prio
// picks the match nearest the head and gives its 1-based position
// ----------------------------------------------------------------------------
module fqs_prio (
  input  logic [fqs_pkg::DEPTH-1:0] match,
  output logic                      found,
  output logic [fqs_pkg::POS_W-1:0] position
);
  import fqs_pkg::*;

  always_comb begin
    position = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        position = POS_W'(i + 1);
      end
    end
  end

  assign found = |match;

endmodule

// ===== hdl/fifo_queue_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_unit
// bounded queue of signed words with push, pop and search by key
// ----------------------------------------------------------------------------
// usage:
//   req carries one command word (push, pop, search) on req_valid; it is
//   taken at a clock edge where req_valid is high and req_stall is low.
//   rsp carries exactly one result word per command on rsp_valid; the
//   receiver holds it with rsp_stall.
// result: registered, and valid in the cycle after acceptance.
// throughput: one command per cycle while req_stall is low; the queue is
//   a row of 16 cells that shift toward the head on pop, load at the first
//   free cell on push and all compare with the key at once on search, so
//   every command finishes in the cycle it is taken.
// stall: while a result waits under rsp_stall, req_stall is raised and no
//   further command is taken.
// reset: empties the queue and drops any pending result; no clearing pass.
// push to a full queue is dropped with status full; pop on an empty queue
//   reports empty; an unused command code leaves the queue unchanged.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fqs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output fqs_pkg::rsp_t rsp
);
  import fqs_pkg::*;

  `include "fifo_queue_with_search_unit_macros.svh"

  logic                accept;
  logic                full;
  logic                empty;
  logic                found;
  logic [POS_W-1:0]    hit_pos;
  logic [DEPTH-1:0]    cell_valid;
  logic [DEPTH-1:0]    cell_match;
  word_t               cell_data [DEPTH];
  cell_ctrl_t          ctrl;
  rsp_t                rsp_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = cell_valid[DEPTH-1];
  assign empty     = !cell_valid[0];

  assign ctrl.push = accept && (req.cmd == CMD_PUSH) && !full;
  assign ctrl.pop  = accept && (req.cmd == CMD_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  prev_v;
    logic  next_v;
    word_t next_d;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_d = '0;
    end else begin : g_inner
      assign next_v = cell_valid[i+1];
      assign next_d = cell_data[i+1];
    end

    fqs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .word       (req.value),
      .prev_valid (prev_v),
      .next_valid (next_v),
      .next_data  (next_d),
      .valid      (cell_valid[i]),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  fqs_prio u_prio (
    .match    (cell_match),
    .found    (found),
    .position (hit_pos)
  );

  always_comb begin
    rsp_next.status   = ST_OK;
    rsp_next.data_out = '0;
    rsp_next.position = '0;
    unique case (req.cmd)
      CMD_PUSH: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end
      end
      CMD_POP: begin
        if (empty) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rsp_next.data_out = cell_data[0];
        end
      end
      CMD_SEARCH: begin
        if (found) begin
          rsp_next.status   = ST_FOUND;
          rsp_next.position = hit_pos;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= accept || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // occupied cells stay packed against the head
  `FQS_ASSERT_IMP(a_packed, clk, rst, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0)
  `FQS_ASSERT_NXT(a_push_grows, clk, rst, ctrl.push, $countones(cell_valid) == $countones($past(cell_valid)) + 1)
  `FQS_ASSERT_NXT(a_pop_shrinks, clk, rst, ctrl.pop, $countones(cell_valid) + 1 == $countones($past(cell_valid)))
  `FQS_ASSERT_NXT(a_hit_found, clk, rst, accept && (req.cmd == CMD_SEARCH) && found, rsp_valid && (rsp.status == ST_FOUND) && (rsp.position != '0))

endmodule
